// File: sv/fast_inverse_square_root_defines.svh
// Assertion macros for the fast inverse square root block.
// No dependencies; taken in by the top level with an include.
`ifndef FAST_INVERSE_SQUARE_ROOT_DEFINES_SVH
`define FAST_INVERSE_SQUARE_ROOT_DEFINES_SVH
`ifndef SYNTHESIS
`define FISR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fisr: same-cycle check failed");
`define FISR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fisr: next-cycle check failed");
`else
`define FISR_ASSERT_IMPL(lbl, ante, cons)
`define FISR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: sv/fisr_pkg.sv
// Package for the fast inverse square root block: binary32 constants,
// the pre-rounding struct and the multiply, add and round functions. No dependencies.
`default_nettype none
package fisr_pkg;

  localparam logic [31:0] SeedMagic = 32'h5f3759df;
  localparam logic [31:0] FpHalf    = 32'h3f000000;
  localparam logic [31:0] FpOneHalf = 32'h3fc00000;
  localparam logic [31:0] QuietBit  = 32'h00400000;
  localparam logic [31:0] DefNan    = 32'hffc00000;
  localparam int unsigned ManW      = 50;

  // Unrounded result: value = man * 2^(ex - 127 - 49), or a special value.
  typedef struct packed {
    logic                      sgn;
    logic signed [11:0]        ex;
    logic [ManW-1:0]           man;
    logic                      spc;
    logic [31:0]               spv;
  } fpre_t;

  function automatic fpre_t mul_pre(logic [31:0] a, logic [31:0] b);
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [47:0] p;
    logic        an, bn, ai, bi, az, bz;
    fpre_t       r;
    ea = a[30:23];
    eb = b[30:23];
    an = (&ea) && (|a[22:0]);
    bn = (&eb) && (|b[22:0]);
    ai = (&ea) && !(|a[22:0]);
    bi = (&eb) && !(|b[22:0]);
    az = (ea == 8'd0) && !(|a[22:0]);
    bz = (eb == 8'd0) && !(|b[22:0]);
    ma = {|ea, a[22:0]};
    mb = {|eb, b[22:0]};
    p  = ma * mb;
    r.sgn = a[31] ^ b[31];
    r.ex  = $signed({4'b0, ((ea == 8'd0) ? 8'd1 : ea)})
          + $signed({4'b0, ((eb == 8'd0) ? 8'd1 : eb)}) - 12'sd126;
    r.man = {p, 2'b00};
    r.spc = 1'b0;
    r.spv = '0;
    if (an) begin
      r.spc = 1'b1;
      r.spv = a | QuietBit;
    end else if (bn) begin
      r.spc = 1'b1;
      r.spv = b | QuietBit;
    end else if ((ai && bz) || (bi && az)) begin
      r.spc = 1'b1;
      r.spv = DefNan;
    end else if (ai || bi) begin
      r.spc = 1'b1;
      r.spv = {r.sgn, 8'hff, 23'd0};
    end
    return r;
  endfunction

  // a + b, or a - b when sub is set; NaN operands propagate unnegated.
  function automatic fpre_t add_pre(logic [31:0] a, logic [31:0] b, logic sub);
    logic [31:0]     bb;
    logic [31:0]     big;
    logic [31:0]     sml;
    logic [7:0]      eg;
    logic [7:0]      es;
    logic [7:0]      d;
    logic [ManW-1:0] mg;
    logic [ManW-1:0] ms;
    logic [ManW-1:0] sm;
    logic [ManW-1:0] lostmask;
    logic [ManW-1:0] sum;
    logic            an, bn, ai, bi, diff;
    fpre_t           r;
    bb = {b[31] ^ sub, b[30:0]};
    an = (&a[30:23]) && (|a[22:0]);
    bn = (&b[30:23]) && (|b[22:0]);
    ai = (&a[30:23]) && !(|a[22:0]);
    bi = (&b[30:23]) && !(|b[22:0]);
    diff = a[31] ^ bb[31];
    if (bb[30:0] > a[30:0]) begin
      big = bb;
      sml = a;
    end else begin
      big = a;
      sml = bb;
    end
    eg = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d  = eg - es;
    mg = {1'b0, |big[30:23], big[22:0], 25'd0};
    ms = {1'b0, |sml[30:23], sml[22:0], 25'd0};
    lostmask = ~({ManW{1'b1}} << d);
    sm  = (ms >> d) | {{(ManW-1){1'b0}}, |(ms & lostmask)};
    sum = diff ? (mg - sm) : (mg + sm);
    r.sgn = (diff && (sum == '0)) ? 1'b0 : big[31];
    r.ex  = $signed({4'b0, eg}) + 12'sd1;
    r.man = sum;
    r.spc = 1'b0;
    r.spv = '0;
    if (an) begin
      r.spc = 1'b1;
      r.spv = a | QuietBit;
    end else if (bn) begin
      r.spc = 1'b1;
      r.spv = b | QuietBit;
    end else if (ai && bi && diff) begin
      r.spc = 1'b1;
      r.spv = DefNan;
    end else if (ai) begin
      r.spc = 1'b1;
      r.spv = a;
    end else if (bi) begin
      r.spc = 1'b1;
      r.spv = bb;
    end
    return r;
  endfunction

  // Normalise, denormalise if needed, round to nearest even, pack.
  function automatic logic [31:0] norm_round(fpre_t p);
    logic [5:0]         lz;
    logic [ManW-1:0]    mn;
    logic signed [11:0] en;
    logic [11:0]        sh;
    logic               st;
    logic [7:0]         ef;
    logic               up;
    logic [30:0]        body;
    lz = '0;
    for (int i = 0; i < ManW; i++) begin
      if (p.man[i]) lz = 6'(ManW - 1 - i);
    end
    mn = p.man << lz;
    en = p.ex - $signed({6'b0, lz});
    st = 1'b0;
    ef = '0;
    if (en <= 12'sd0) begin
      sh = 12'(12'sd1 - en);
      st = |(mn & ~({ManW{1'b1}} << sh));
      mn = mn >> sh;
    end else begin
      ef = en[7:0];
    end
    up   = mn[25] && (st || (|mn[24:0]) || mn[26]);
    body = {ef, mn[48:26]} + 31'(up);
    if (p.spc) return p.spv;
    if (p.man == '0) return {p.sgn, 31'd0};
    if (en >= 12'sd255) return {p.sgn, 8'hff, 23'd0};
    return {p.sgn, body};
  endfunction

endpackage
`default_nettype wire

// File: sv/fast_inverse_square_root.sv
// Top level of the fast inverse square root block: eight-stage binary32 pipeline.
// Depends on fisr_pkg and fast_inverse_square_root_defines.svh.
`default_nettype none
`include "fast_inverse_square_root_defines.svh"
// Takes one binary32 bit pattern a beat and returns the magic-constant seed
// refined by one Newton step, all float steps rounded to nearest even with
// subnormals, infinities and NaNs kept. One beat enters every cycle while the
// output does not stall; out_valid_o follows the valid bit of each beat through
// vld_q to the output register res8_q. Each float operation takes two
// stages: a raw stage (24x24 multiply, or align and add) and a normalise and
// round stage. A stall at the output freezes the whole pipeline, so in_stall_o
// follows out_stall_i whenever the output register holds a beat.
module fast_inverse_square_root (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [31:0] x_bits_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [31:0] r_bits_o
);

  logic [7:0] vld_q;
  logic       adv;

  // stage payloads
  logic [31:0]          r1_q, r2_q, r3_q, r4_q, r5_q, r6_q;
  fisr_pkg::fpre_t      yp1_q, rrp1_q, tp3_q, up5_q, rp7_q;
  logic [31:0]          y2_q, rr2_q, t4_q, u6_q, res8_q;
  logic [31:0]          seed;

  assign adv        = !(vld_q[7] && out_stall_i);
  assign in_stall_o = !adv;
  assign out_valid_o = vld_q[7];
  assign r_bits_o    = res8_q;

  // seed: magic minus input shifted right arithmetically by one
  assign seed = fisr_pkg::SeedMagic - {x_bits_i[31], x_bits_i[31:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[6:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1: raw y = x*0.5 and rr = r*r
      r1_q   <= seed;
      yp1_q  <= fisr_pkg::mul_pre(x_bits_i, fisr_pkg::FpHalf);
      rrp1_q <= fisr_pkg::mul_pre(seed, seed);
      // stage 2: round both
      r2_q   <= r1_q;
      y2_q   <= fisr_pkg::norm_round(yp1_q);
      rr2_q  <= fisr_pkg::norm_round(rrp1_q);
      // stages 3-4: t = rr*y
      r3_q   <= r2_q;
      tp3_q  <= fisr_pkg::mul_pre(rr2_q, y2_q);
      r4_q   <= r3_q;
      t4_q   <= fisr_pkg::norm_round(tp3_q);
      // stages 5-6: u = 1.5 - t
      r5_q   <= r4_q;
      up5_q  <= fisr_pkg::add_pre(fisr_pkg::FpOneHalf, t4_q, 1'b1);
      r6_q   <= r5_q;
      u6_q   <= fisr_pkg::norm_round(up5_q);
      // stages 7-8: result = r*u
      rp7_q  <= fisr_pkg::mul_pre(r6_q, u6_q);
      res8_q <= fisr_pkg::norm_round(rp7_q);
    end
  end

  `FISR_ASSERT_IMPL(a_stall_link, 1'b1, in_stall_o == (out_valid_o && out_stall_i))
  `FISR_ASSERT_NEXT(a_accept_enters, in_valid_i && !in_stall_o, vld_q[0])
  `FISR_ASSERT_NEXT(a_last_stage_out, vld_q[6] && !in_stall_o, out_valid_o)

endmodule
`default_nettype wire

// File: sim/fisr_checker.sv
`timescale 1ns / 100ps
// Checker for the fast inverse square root block: watches both channels,
// predicts each result with its own binary32 arithmetic and compares. Needs fisr_pkg.
module fisr_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [31:0]       x_bits_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [31:0]       r_bits_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o
);

  localparam logic [31:0] QuietNanBit = 32'h00400000;
  localparam logic [31:0] DefaultNan  = 32'hffc00000;
  localparam logic [31:0] FloatHalf   = 32'h3f000000;
  localparam logic [31:0] FloatOneHalf = 32'h3fc00000;
  localparam int          WideW       = 300;

  typedef logic [WideW-1:0] wide_t;

  typedef struct {
    logic        sgn;
    int          ex;    // value = man * 2^ex
    logic [23:0] man;
  } unpacked_t;

  logic [31:0] expected_r_q[$];

  function automatic bit is_nan(logic [31:0] a);
    return (&a[30:23]) && (|a[22:0]);
  endfunction

  function automatic bit is_inf(logic [31:0] a);
    return (&a[30:23]) && !(|a[22:0]);
  endfunction

  function automatic unpacked_t unpack_single(logic [31:0] a);
    unpacked_t u;
    u.sgn = a[31];
    if (a[30:23] == 8'd0) begin
      u.ex  = -149;
      u.man = {1'b0, a[22:0]};
    end else begin
      u.ex  = int'(a[30:23]) - 150;
      u.man = {1'b1, a[22:0]};
    end
    return u;
  endfunction

  // Round mag * 2^ex to nearest even and pack, subnormals and overflow included.
  function automatic logic [31:0] round_to_single(logic sgn, wide_t mag, int ex);
    int    msb;
    int    sh;
    int    q;
    wide_t kept;
    wide_t lowmask;
    logic  guard;
    logic  sticky;
    if (mag == '0) return {sgn, 31'd0};
    msb = 0;
    for (int i = 0; i < WideW; i++) if (mag[i]) msb = i;
    sh = msb - 23;
    if (sh < -149 - ex) sh = -149 - ex;
    if (sh > 0) begin
      kept    = mag >> sh;
      guard   = mag[sh-1];
      lowmask = ~({WideW{1'b1}} << (sh - 1));
      sticky  = |(mag & lowmask);
      if (guard && (sticky || kept[0])) kept = kept + 1'b1;
    end else begin
      kept = mag << (-sh);
    end
    q = ex + sh;
    if (kept[24]) begin
      kept = kept >> 1;
      q++;
    end
    if (!kept[23]) return {sgn, 8'd0, kept[22:0]};
    if (q + 150 >= 255) return {sgn, 8'hff, 23'd0};
    return {sgn, 8'(q + 150), kept[22:0]};
  endfunction

  function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
    unpacked_t ua;
    unpacked_t ub;
    logic      sgn;
    sgn = a[31] ^ b[31];
    if (is_nan(a)) return a | QuietNanBit;
    if (is_nan(b)) return b | QuietNanBit;
    if ((is_inf(a) && b[30:0] == '0) || (is_inf(b) && a[30:0] == '0)) return DefaultNan;
    if (is_inf(a) || is_inf(b)) return {sgn, 8'hff, 23'd0};
    ua = unpack_single(a);
    ub = unpack_single(b);
    return round_to_single(sgn, wide_t'(ua.man) * wide_t'(ub.man), ua.ex + ub.ex);
  endfunction

  // a - b; a NaN operand comes back quieted with its own sign.
  function automatic logic [31:0] fsub(logic [31:0] a, logic [31:0] b);
    logic [31:0] nb;
    unpacked_t   ua;
    unpacked_t   ub;
    int          e;
    wide_t       wa;
    wide_t       wb;
    nb = {~b[31], b[30:0]};
    if (is_nan(a)) return a | QuietNanBit;
    if (is_nan(b)) return b | QuietNanBit;
    if (is_inf(a) && is_inf(nb) && (a[31] != nb[31])) return DefaultNan;
    if (is_inf(a)) return a;
    if (is_inf(nb)) return nb;
    ua = unpack_single(a);
    ub = unpack_single(nb);
    e  = (ua.ex < ub.ex) ? ua.ex : ub.ex;
    wa = wide_t'(ua.man) << (ua.ex - e);
    wb = wide_t'(ub.man) << (ub.ex - e);
    if (ua.sgn == ub.sgn) return round_to_single(ua.sgn, wa + wb, e);
    if (wa == wb) return 32'h0;
    if (wa > wb) return round_to_single(ua.sgn, wa - wb, e);
    return round_to_single(ub.sgn, wb - wa, e);
  endfunction

  function automatic logic [31:0] predict_rsqrt(logic [31:0] x);
    logic [31:0] y;
    logic [31:0] seed;
    logic [31:0] rr;
    logic [31:0] t;
    logic [31:0] u;
    y    = fmul(x, FloatHalf);
    seed = fisr_pkg::SeedMagic - {x[31], x[31:1]};
    rr   = fmul(seed, seed);
    t    = fmul(rr, y);
    u    = fsub(FloatOneHalf, t);
    return fmul(seed, u);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] want;
    if (!rst_ni) begin
      expected_r_q.delete();
      fail_count_o <= 0;
      checked_o    <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_r_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: unexpected result beat r_bits=%h", $time, r_bits_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_r_q.pop_front();
          checked_o <= checked_o + 1;
          if (r_bits_i !== want) begin
            if (fail_count_o < 10)
              $display("%0t: r_bits mismatch: expected %h, got %h", $time, want, r_bits_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_r_q.push_back(predict_rsqrt(x_bits_i));
      pending_o <= expected_r_q.size();
    end
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Top of the fast inverse square root testbench: clock, reset, stimulus and verdict.
// Needs fast_inverse_square_root, fisr_pkg and fisr_checker.
module tb_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] x_bits_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] r_bits_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned sent;
  int unsigned idle_pct;   // sender gap probability per cycle
  int unsigned stall_pct;  // receiver stall probability per cycle

  always #2 clk_i = ~clk_i;

  fast_inverse_square_root i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .x_bits_i   (x_bits_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .r_bits_o   (r_bits_o)
  );

  fisr_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .x_bits_i    (x_bits_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .r_bits_i    (r_bits_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // Receiver back-pressure, one decision per cycle.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // One beat: optional gap first, then hold until accepted.
  task automatic send_beat(logic [31:0] x);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_bits_i   <= x;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  // Random operand: mostly ordinary positive floats, then the odd corners.
  function automatic logic [31:0] random_operand();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return {1'b0, 8'($urandom_range(254, 1)), 23'($urandom)};
    if (pick < 65) return $urandom;
    if (pick < 75) return {1'b0, 8'($urandom_range(140, 110)), 23'($urandom)};
    if (pick < 83) return {1'($urandom), 8'd0, 23'($urandom)};           // subnormal
    if (pick < 90) return {1'($urandom), 8'hff, 23'($urandom_range(3))}; // inf / NaN
    if (pick < 95) return {1'b1, 8'($urandom_range(254, 1)), 23'($urandom)};
    return {1'($urandom), 8'($urandom_range(254, 250)), 23'($urandom)};  // near overflow
  endfunction

  localparam logic [31:0] Corners[18] = '{
    32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000, 32'h7fc00000,
    32'h7f800001, 32'hffffffff, 32'h00000001, 32'h007fffff, 32'h00800000,
    32'h3f800000, 32'h40800000, 32'h7f7fffff, 32'hbf800000, 32'h3e800000,
    32'h5f3759df, 32'haaaaaaaa, 32'h55555555
  };

  initial begin
    sent      = 0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zeros, infinities, NaNs, subnormals, negatives, extremes.
    foreach (Corners[i]) send_beat(Corners[i]);

    // Random phases: no idling, sender gaps, receiver stalls, both.
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1) ? 54 : (phase == 3) ? 24 : 0;
      stall_pct = (phase == 2) ? 54 : (phase == 3) ? 24 : 0;
      for (int n = 0; n < 335; n++) send_beat(random_operand());
      if (phase == 1) begin
        // drain fully once before carrying on
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
    end

    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d beats (corner values, then random under gaps and stalls);", sent);
    $display("%0d results checked, %0d failures.", checked, fail_count);
    if (fail_count == 0 && checked == sent) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
